/* rtl/core/gateway_datagram_validator_unit_assert.svh */
// Assertion macros shared by the validator modules.
`ifndef GATEWAY_DATAGRAM_VALIDATOR_UNIT_ASSERT_SVH
`define GATEWAY_DATAGRAM_VALIDATOR_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define GDV_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define GDV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define GDV_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define GDV_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/core/gdv_pkg.sv */
// Package: types, constants and the CRC step of the datagram validator.
package gdv_pkg;
    localparam int HEADER_BYTES_DEF      = 28;
    localparam int MAX_PAYLOAD_BYTES_DEF = 1024;
    localparam int MAX_REPORT_COUNT_DEF  = 32;
    localparam int REPORT_BYTES_DEF      = 32;
    localparam int OFF_W   = 17;
    localparam logic [OFF_W-1:0] OFF_MAX = '1;
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;

    localparam logic [3:0] ERR_OK       = 4'd0;
    localparam logic [3:0] ERR_SHORT    = 4'd1;
    localparam logic [3:0] ERR_MAGIC    = 4'd2;
    localparam logic [3:0] ERR_VERSION  = 4'd3;
    localparam logic [3:0] ERR_KIND     = 4'd4;
    localparam logic [3:0] ERR_REPORTS  = 4'd5;
    localparam logic [3:0] ERR_HDRSIZE  = 4'd6;
    localparam logic [3:0] ERR_PAYLOAD  = 4'd7;
    localparam logic [3:0] ERR_LENGTH   = 4'd8;
    localparam logic [3:0] ERR_CRC      = 4'd9;
    localparam logic [3:0] ERR_BATCH    = 4'd10;
    localparam logic [3:0] ERR_NONBATCH = 4'd11;

    localparam logic [1:0] REG_VERSION = 2'd0;
    localparam logic [1:0] REG_LOWEST  = 2'd1;
    localparam logic [1:0] REG_BATCH   = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic        is_status;
        logic [7:0]  payload_byte;
        logic        frame_ok;
        logic [3:0]  error_code;
        logic [7:0]  msg_kind;
        logic [7:0]  msg_flags;
        logic [7:0]  msg_reports;
        logic [63:0] node_id;
        logic [31:0] boot_id;
        logic [31:0] sequence_number;
        logic [10:0] payload_bytes;
    } t_out_item;

    // Classified work handed from the front part to the back part.
    typedef struct packed {
        logic        is_status;
        logic [7:0]  payload_byte;
        logic        len_short;
        logic        magic_bad;
        logic        version_bad;
        logic        kind_bad;
        logic        reports_bad;
        logic        hdrsize_bad;
        logic        payload_bad;
        logic        length_bad;
        logic        crc_bad;
        logic        is_batch;
        logic        batch_bad;
        logic        nonbatch_bad;
        logic [7:0]  msg_kind;
        logic [7:0]  msg_flags;
        logic [7:0]  msg_reports;
        logic [63:0] node_id;
        logic [31:0] boot_id;
        logic [31:0] sequence_number;
        logic [10:0] payload_bytes;
    } t_work;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction
endpackage

/* rtl/core/gdv_front.sv */
// Front part: captures the header, runs the CRC and classifies each byte.
`include "gateway_datagram_validator_unit_assert.svh"
module gdv_front #(
    parameter int HEADER_BYTES      = gdv_pkg::HEADER_BYTES_DEF,
    parameter int MAX_PAYLOAD_BYTES = gdv_pkg::MAX_PAYLOAD_BYTES_DEF,
    parameter int MAX_REPORT_COUNT  = gdv_pkg::MAX_REPORT_COUNT_DEF,
    parameter int REPORT_BYTES      = gdv_pkg::REPORT_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  gdv_pkg::t_in_item i_item,
    input  logic [7:0]        i_expected_version,
    input  logic [7:0]        i_lowest_kind,
    input  logic [7:0]        i_batch_kind,
    output logic              o_push,
    output gdv_pkg::t_work    o_work
);
    localparam int OW = gdv_pkg::OFF_W;

    logic [OW-1:0]  r_off;
    logic [31:0]    r_crc, r_frozen, r_rx_crc;
    logic           r_magic_good;
    logic [191:0]   r_hdr;
    logic [15:0]    r_len, r_hsize;

    logic [7:0]     b;
    logic [31:0]    crc_next;
    logic [OW-1:0]  off_inc;
    logic [17:0]    pay_end;
    logic           in_payload;
    logic [31:0]    rx_next, frozen_next;
    logic [191:0]   hdr_next;
    logic [15:0]    len_next;
    logic [7:0]     magic_ref;
    logic [7:0]     kind, reports;
    logic [23:0]    rep_prod;

    assign b        = i_item.data_byte;
    assign crc_next = gdv_pkg::crc_byte(r_crc, b);
    assign off_inc  = (r_off == gdv_pkg::OFF_MAX) ? r_off : r_off + 1'b1;
    assign pay_end  = 18'(HEADER_BYTES) + {2'b0, r_len};
    assign in_payload = ({1'b0, r_off} >= 18'(HEADER_BYTES)) && ({1'b0, r_off} < pay_end)
                        && (r_len <= 16'(MAX_PAYLOAD_BYTES));
    assign rx_next  = {b, r_rx_crc[31:8]};
    assign frozen_next = ({1'b0, r_off} + 18'd1 == pay_end) ? ~crc_next : r_frozen;

    always_comb begin
        case (r_off[1:0])
            2'd0:    magic_ref = 8'h53;
            2'd1:    magic_ref = 8'h56;
            2'd2:    magic_ref = 8'h57;
            default: magic_ref = 8'h31;
        endcase
    end

    always_comb begin
        hdr_next = r_hdr;
        len_next = r_len;
        if (r_off < OW'(24)) begin
            hdr_next[r_off[4:0]*8 +: 8] = b;
        end else if (r_off == OW'(24)) begin
            len_next[7:0] = b;
        end else if (r_off == OW'(25)) begin
            len_next[15:8] = b;
        end
    end

    assign kind     = r_hdr[47:40];
    assign reports  = r_hdr[63:56];
    assign rep_prod = 24'(reports) * 24'(REPORT_BYTES);

    // Status checks use the state as it stands after this last byte.
    always_comb begin
        o_work = '0;
        o_work.is_status    = i_item.last_byte;
        o_work.payload_byte = i_item.last_byte ? 8'd0 : b;
        o_work.len_short    = off_inc < OW'(HEADER_BYTES + 4);
        o_work.magic_bad    = !(r_magic_good && !(r_off < OW'(4) && b != magic_ref));
        o_work.version_bad  = r_hdr[39:32] != i_expected_version;
        o_work.kind_bad     = (kind < i_lowest_kind) || (kind > i_batch_kind);
        o_work.reports_bad  = reports > 8'(MAX_REPORT_COUNT);
        o_work.hdrsize_bad  = r_hsize != 16'(HEADER_BYTES);
        o_work.payload_bad  = r_len > 16'(MAX_PAYLOAD_BYTES);
        o_work.length_bad   = {1'b0, off_inc} != pay_end + 18'd4;
        o_work.crc_bad      = rx_next != frozen_next;
        o_work.is_batch     = kind == i_batch_kind;
        o_work.batch_bad    = {8'd0, r_len} != rep_prod;
        o_work.nonbatch_bad = (r_len != 16'd0) || (reports != 8'd0);
        o_work.msg_kind     = kind;
        o_work.msg_flags    = r_hdr[55:48];
        o_work.msg_reports  = reports;
        o_work.node_id      = r_hdr[127:64];
        o_work.boot_id      = r_hdr[159:128];
        o_work.sequence_number = r_hdr[191:160];
        o_work.payload_bytes   = r_len[10:0];
    end

    assign o_push = i_valid && (i_item.last_byte || in_payload);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && i_item.last_byte)) begin
            r_off        <= '0;
            r_crc        <= '1;
            r_frozen     <= '0;
            r_rx_crc     <= '0;
            r_magic_good <= 1'b1;
            r_hdr        <= '0;
            r_len        <= '0;
            r_hsize      <= '0;
        end else if (i_valid) begin
            r_off    <= off_inc;
            r_crc    <= crc_next;
            r_frozen <= frozen_next;
            r_rx_crc <= rx_next;
            r_hdr    <= hdr_next;
            r_len    <= len_next;
            if (r_off < OW'(4) && b != magic_ref) begin
                r_magic_good <= 1'b0;
            end
            if (r_off == OW'(26)) begin
                r_hsize[7:0] <= b;
            end else if (r_off == OW'(27)) begin
                r_hsize[15:8] <= b;
            end
        end
    end

    `GDV_ASSERT_NEXT(a_last_clears, i_clk, i_rst_n, i_valid && i_item.last_byte, r_off == '0)
    `GDV_ASSERT_IMP(a_off_sat, i_clk, i_rst_n, r_off == gdv_pkg::OFF_MAX && i_valid && !i_item.last_byte, off_inc == r_off)
    `GDV_ASSERT_IMP(a_push_last, i_clk, i_rst_n, i_valid && i_item.last_byte, o_push)
endmodule

/* rtl/core/gdv_back.sv */
// Back part: short queue of classified work and the status resolver.
`include "gateway_datagram_validator_unit_assert.svh"
module gdv_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  gdv_pkg::t_work     i_work,
    output logic               o_has_room,
    output logic               o_valid,
    input  logic               i_ready,
    output gdv_pkg::t_out_item o_item
);
    localparam int DEPTH = 4;

    gdv_pkg::t_work r_q [DEPTH];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       pop;
    gdv_pkg::t_work h;
    logic [3:0] code;

    assign o_has_room = r_cnt < 3'(DEPTH);
    assign o_valid    = r_cnt != 3'd0;
    assign pop        = o_valid && i_ready;
    assign h          = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_work;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + 3'(i_push) - 3'(pop);
        end
    end

    always_comb begin
        if (h.len_short)           code = gdv_pkg::ERR_SHORT;
        else if (h.magic_bad)      code = gdv_pkg::ERR_MAGIC;
        else if (h.version_bad)    code = gdv_pkg::ERR_VERSION;
        else if (h.kind_bad)       code = gdv_pkg::ERR_KIND;
        else if (h.reports_bad)    code = gdv_pkg::ERR_REPORTS;
        else if (h.hdrsize_bad)    code = gdv_pkg::ERR_HDRSIZE;
        else if (h.payload_bad)    code = gdv_pkg::ERR_PAYLOAD;
        else if (h.length_bad)     code = gdv_pkg::ERR_LENGTH;
        else if (h.crc_bad)        code = gdv_pkg::ERR_CRC;
        else if (h.is_batch && h.batch_bad)     code = gdv_pkg::ERR_BATCH;
        else if (!h.is_batch && h.nonbatch_bad) code = gdv_pkg::ERR_NONBATCH;
        else                       code = gdv_pkg::ERR_OK;
    end

    always_comb begin
        o_item = '0;
        o_item.is_status    = h.is_status;
        o_item.payload_byte = h.payload_byte;
        if (h.is_status) begin
            o_item.error_code = code;
            if (code == gdv_pkg::ERR_OK) begin
                o_item.frame_ok        = 1'b1;
                o_item.msg_kind        = h.msg_kind;
                o_item.msg_flags       = h.msg_flags;
                o_item.msg_reports     = h.msg_reports;
                o_item.node_id         = h.node_id;
                o_item.boot_id         = h.boot_id;
                o_item.sequence_number = h.sequence_number;
                o_item.payload_bytes   = h.payload_bytes;
            end
        end
    end

    `GDV_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, i_push, r_cnt < 3'(DEPTH) || pop)
    `GDV_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready && !i_push, r_cnt == $past(r_cnt))
    `GDV_ASSERT_IMP(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt <= 3'(DEPTH))
endmodule

/* rtl/core/gateway_datagram_validator_unit.sv */
// Top level of the gateway datagram validator.
// Each output item is first registered in the four-entry queue of the back part.
// Throughput: one byte per cycle; the four-entry queue stalls input when full.
// Reset (synchronous, active low) clears frame state, the queue, and sets
// registers to version 1, lowest kind 1, batch kind 4.
module gateway_datagram_validator_unit #(
    parameter int HEADER_BYTES      = gdv_pkg::HEADER_BYTES_DEF,
    parameter int MAX_PAYLOAD_BYTES = gdv_pkg::MAX_PAYLOAD_BYTES_DEF,
    parameter int MAX_REPORT_COUNT  = gdv_pkg::MAX_REPORT_COUNT_DEF,
    parameter int REPORT_BYTES      = gdv_pkg::REPORT_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  gdv_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output gdv_pkg::t_out_item o_item,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [7:0]         i_cfg_data
);
    logic [7:0] r_ver, r_low, r_batch;
    logic push, room;
    gdv_pkg::t_work work;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ver   <= 8'd1;
            r_low   <= 8'd1;
            r_batch <= 8'd4;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                gdv_pkg::REG_VERSION: r_ver   <= i_cfg_data;
                gdv_pkg::REG_LOWEST:  r_low   <= i_cfg_data;
                gdv_pkg::REG_BATCH:   r_batch <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_ready = room;

    gdv_front #(
        .HEADER_BYTES(HEADER_BYTES), .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES),
        .MAX_REPORT_COUNT(MAX_REPORT_COUNT), .REPORT_BYTES(REPORT_BYTES)
    ) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid && room), .i_item(i_item),
        .i_expected_version(r_ver), .i_lowest_kind(r_low), .i_batch_kind(r_batch),
        .o_push(push), .o_work(work)
    );

    gdv_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .i_work(work), .o_has_room(room),
        .o_valid(o_valid), .i_ready(i_ready), .o_item(o_item)
    );
endmodule
